### sv/cfs_pkg.sv
// shared types and codes for the chained free block stack
package cfs_pkg;

    localparam int BLK_W    = 31;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GROUP = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ALLOCATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_READ_GROUP = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SPILL_WORD = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREED      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_GROUP  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_UNEXPECTED = 3'd6;

    typedef logic [1:0] wr_addr_sel_t;
    localparam wr_addr_sel_t WA_ZERO  = 2'd0;
    localparam wr_addr_sel_t WA_POS   = 2'd1;
    localparam wr_addr_sel_t WA_COUNT = 2'd2;

    typedef logic [1:0] wr_data_sel_t;
    localparam wr_data_sel_t WD_ZERO = 2'd0;
    localparam wr_data_sel_t WD_WORD = 2'd1;
    localparam wr_data_sel_t WD_BLK  = 2'd2;

    typedef logic rd_addr_sel_t;
    localparam rd_addr_sel_t RA_COUNT_M1  = 1'b0;
    localparam rd_addr_sel_t RA_SPILL_IDX = 1'b1;

    typedef logic [2:0] count_op_t;
    localparam count_op_t CNT_HOLD  = 3'd0;
    localparam count_op_t CNT_DEC   = 3'd1;
    localparam count_op_t CNT_INC   = 3'd2;
    localparam count_op_t CNT_ONE   = 3'd3;
    localparam count_op_t CNT_ZERO  = 3'd4;
    localparam count_op_t CNT_WORD  = 3'd5;
    localparam count_op_t CNT_DEPTH = 3'd6;

    typedef logic [1:0] blk_sel_t;
    localparam blk_sel_t BS_ZERO    = 2'd0;
    localparam blk_sel_t BS_ITEM    = 2'd1;
    localparam blk_sel_t BS_RD      = 2'd2;
    localparam blk_sel_t BS_PENDING = 2'd3;

    typedef logic [1:0] word_sel_t;
    localparam word_sel_t WS_ZERO  = 2'd0;
    localparam word_sel_t WS_COUNT = 2'd1;
    localparam word_sel_t WS_RD    = 2'd2;
    localparam word_sel_t WS_WORD  = 2'd3;

    typedef struct packed {
        logic                load_item;
        logic                set_modified;
        logic                mem_wr;
        wr_addr_sel_t        wr_addr_sel;
        wr_data_sel_t        wr_data_sel;
        logic                mem_rd;
        rd_addr_sel_t        rd_addr_sel;
        count_op_t           count_op;
        logic                spill_clr;
        logic                spill_inc;
        logic                refill_start;
        logic                refill_end;
        logic                pos_first;
        logic                pos_inc;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
        blk_sel_t            blk_sel;
        word_sel_t           word_sel;
        logic                out_last;
    } cfs_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              refill;
        logic              count_zero;
        logic              count_full;
        logic              pos_zero;
        logic              pos_last;
        logic              word_big;
        logic              rd_zero;
        logic              spill_done;
        logic              out_free;
    } cfs_stat_t;

endpackage

### sv/cfs_ctrl.sv
// controller state machine for the chained free block stack
module cfs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cfs_pkg::cfs_stat_t  stat,
    output cfs_pkg::cfs_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECODE    = 3'd1;
    localparam logic [2:0] S_ALLOC_RD  = 3'd2;
    localparam logic [2:0] S_SPILL_CNT = 3'd3;
    localparam logic [2:0] S_SPILL     = 3'd4;
    localparam logic [2:0] S_PUSH      = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.kind == cfs_pkg::KIND_ALLOC && !stat.refill)
                begin
                    if (stat.count_zero)
                    begin
                        if (stat.out_free)
                        begin
                            cmd.set_modified = 1'b1;
                            cmd.out_load     = 1'b1;
                            cmd.out_status   = cfs_pkg::ST_NO_SPACE;
                            cmd.blk_sel      = cfs_pkg::BS_ZERO;
                            cmd.word_sel     = cfs_pkg::WS_ZERO;
                            cmd.out_last     = 1'b1;
                            state_next       = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.set_modified = 1'b1;
                        cmd.count_op     = cfs_pkg::CNT_DEC;
                        cmd.mem_rd       = 1'b1;
                        cmd.rd_addr_sel  = cfs_pkg::RA_COUNT_M1;
                        state_next       = S_ALLOC_RD;
                    end
                end
                else if (stat.kind == cfs_pkg::KIND_FREE && !stat.refill)
                begin
                    cmd.set_modified = 1'b1;
                    if (stat.count_zero)
                    begin
                        // plant the end marker before the push
                        cmd.mem_wr      = 1'b1;
                        cmd.wr_addr_sel = cfs_pkg::WA_ZERO;
                        cmd.wr_data_sel = cfs_pkg::WD_ZERO;
                        cmd.count_op    = cfs_pkg::CNT_ONE;
                        state_next      = S_PUSH;
                    end
                    else if (stat.count_full)
                    begin
                        cmd.spill_clr = 1'b1;
                        state_next    = S_SPILL_CNT;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
                else if (stat.kind == cfs_pkg::KIND_GROUP && stat.refill)
                begin
                    if (stat.pos_zero)
                    begin
                        if (!stat.word_big)
                        begin
                            cmd.count_op  = cfs_pkg::CNT_WORD;
                            cmd.pos_first = 1'b1;
                            state_next    = S_IDLE;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.count_op   = cfs_pkg::CNT_DEPTH;
                            cmd.pos_first  = 1'b1;
                            cmd.out_load   = 1'b1;
                            cmd.out_status = cfs_pkg::ST_BAD_GROUP;
                            cmd.blk_sel    = cfs_pkg::BS_PENDING;
                            cmd.word_sel   = cfs_pkg::WS_WORD;
                            cmd.out_last   = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    else if (!stat.pos_last)
                    begin
                        cmd.mem_wr      = 1'b1;
                        cmd.wr_addr_sel = cfs_pkg::WA_POS;
                        cmd.wr_data_sel = cfs_pkg::WD_WORD;
                        cmd.pos_inc     = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else if (stat.out_free)
                    begin
                        // last group word completes the pending allocation
                        cmd.mem_wr       = 1'b1;
                        cmd.wr_addr_sel  = cfs_pkg::WA_POS;
                        cmd.wr_data_sel  = cfs_pkg::WD_WORD;
                        cmd.refill_end   = 1'b1;
                        cmd.set_modified = 1'b1;
                        cmd.out_load     = 1'b1;
                        cmd.out_status   = cfs_pkg::ST_ALLOCATED;
                        cmd.blk_sel      = cfs_pkg::BS_PENDING;
                        cmd.word_sel     = cfs_pkg::WS_ZERO;
                        cmd.out_last     = 1'b1;
                        state_next       = S_IDLE;
                    end
                end
                else if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = cfs_pkg::ST_UNEXPECTED;
                    cmd.blk_sel    = cfs_pkg::BS_ZERO;
                    cmd.word_sel   = cfs_pkg::WS_ZERO;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_ALLOC_RD:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.word_sel = cfs_pkg::WS_ZERO;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                    if (stat.rd_zero)
                    begin
                        cmd.count_op   = cfs_pkg::CNT_ONE;
                        cmd.out_status = cfs_pkg::ST_NO_SPACE;
                        cmd.blk_sel    = cfs_pkg::BS_ZERO;
                    end
                    else if (stat.count_zero)
                    begin
                        cmd.refill_start = 1'b1;
                        cmd.out_status   = cfs_pkg::ST_READ_GROUP;
                        cmd.blk_sel      = cfs_pkg::BS_RD;
                    end
                    else
                    begin
                        cmd.out_status = cfs_pkg::ST_ALLOCATED;
                        cmd.blk_sel    = cfs_pkg::BS_RD;
                    end
                end
            end
            S_SPILL_CNT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_status  = cfs_pkg::ST_SPILL_WORD;
                    cmd.blk_sel     = cfs_pkg::BS_ITEM;
                    cmd.word_sel    = cfs_pkg::WS_COUNT;
                    cmd.mem_rd      = 1'b1;
                    cmd.rd_addr_sel = cfs_pkg::RA_SPILL_IDX;
                    cmd.spill_inc   = 1'b1;
                    state_next      = S_SPILL;
                end
            end
            S_SPILL:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = cfs_pkg::ST_SPILL_WORD;
                    cmd.blk_sel    = cfs_pkg::BS_ITEM;
                    cmd.word_sel   = cfs_pkg::WS_RD;
                    if (stat.spill_done)
                    begin
                        cmd.count_op = cfs_pkg::CNT_ZERO;
                        state_next   = S_PUSH;
                    end
                    else
                    begin
                        cmd.mem_rd      = 1'b1;
                        cmd.rd_addr_sel = cfs_pkg::RA_SPILL_IDX;
                        cmd.spill_inc   = 1'b1;
                    end
                end
            end
            S_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.mem_wr      = 1'b1;
                    cmd.wr_addr_sel = cfs_pkg::WA_COUNT;
                    cmd.wr_data_sel = cfs_pkg::WD_BLK;
                    cmd.count_op    = cfs_pkg::CNT_INC;
                    cmd.out_load    = 1'b1;
                    cmd.out_status  = cfs_pkg::ST_FREED;
                    cmd.blk_sel     = cfs_pkg::BS_ITEM;
                    cmd.word_sel    = cfs_pkg::WS_ZERO;
                    cmd.out_last    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |-> state_reg == S_IDLE)
        else $error("item loaded outside idle");

    a_spill_to_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPILL && stat.out_free && stat.spill_done) |=> state_reg == S_PUSH)
        else $error("spill end did not lead to push");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_wr && cmd.mem_rd) |-> 1'b0)
        else $error("stack read and written in one cycle");
`endif

endmodule

### sv/cfs_dp.sv
// datapath: stack memory, counters, item and result registers
module cfs_dp
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  cfs_pkg::cfs_cmd_t                   cmd,
    output cfs_pkg::cfs_stat_t                  stat,
    input  logic [cfs_pkg::KIND_W-1:0]          kind,
    input  logic [cfs_pkg::BLK_W-1:0]           block_number,
    input  logic [cfs_pkg::BLK_W-1:0]           group_word,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cfs_pkg::STATUS_W-1:0]        status,
    output logic [cfs_pkg::BLK_W-1:0]           block_number_res,
    output logic [cfs_pkg::BLK_W-1:0]           spill_word,
    output logic                                last,
    output logic                                modified
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int BW = cfs_pkg::BLK_W;

    logic [BW-1:0]               mem [STACK_DEPTH];
    logic [BW-1:0]               rd_data_reg;

    logic [cfs_pkg::KIND_W-1:0]  kind_reg;
    logic [BW-1:0]               blk_reg;
    logic [BW-1:0]               word_reg;

    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic [CW-1:0]               pos_reg;
    logic [CW-1:0]               pos_next;
    logic [CW-1:0]               spill_idx_reg;
    logic [CW-1:0]               spill_idx_next;
    logic                        modified_reg;
    logic                        modified_next;
    logic                        refill_reg;
    logic                        refill_next;
    logic [BW-1:0]               pending_reg;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [cfs_pkg::STATUS_W-1:0] status_reg;
    logic [BW-1:0]               blk_res_reg;
    logic [BW-1:0]               word_res_reg;
    logic                        last_reg;
    logic                        modified_res_reg;

    logic [CW-1:0]               count_m1;
    logic [CW-1:0]               pos_m1;
    logic [AW-1:0]               wr_addr;
    logic [BW-1:0]               wr_data;
    logic [AW-1:0]               rd_addr;
    logic [BW-1:0]               blk_sel_val;
    logic [BW-1:0]               word_sel_val;

    assign count_m1 = count_reg - CW'(1);
    assign pos_m1   = pos_reg - CW'(1);

    always_comb
    begin
        case (cmd.wr_addr_sel)
            cfs_pkg::WA_POS:   wr_addr = pos_m1[AW-1:0];
            cfs_pkg::WA_COUNT: wr_addr = count_reg[AW-1:0];
            default:           wr_addr = '0;
        endcase
        case (cmd.wr_data_sel)
            cfs_pkg::WD_WORD: wr_data = word_reg;
            cfs_pkg::WD_BLK:  wr_data = blk_reg;
            default:          wr_data = '0;
        endcase
        rd_addr = (cmd.rd_addr_sel == cfs_pkg::RA_SPILL_IDX) ? spill_idx_reg[AW-1:0]
                                                             : count_m1[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        case (cmd.count_op)
            cfs_pkg::CNT_DEC:   count_next = count_m1;
            cfs_pkg::CNT_INC:   count_next = count_reg + CW'(1);
            cfs_pkg::CNT_ONE:   count_next = CW'(1);
            cfs_pkg::CNT_ZERO:  count_next = '0;
            cfs_pkg::CNT_WORD:  count_next = word_reg[CW-1:0];
            cfs_pkg::CNT_DEPTH: count_next = CW'(STACK_DEPTH);
            default:            count_next = count_reg;
        endcase

        pos_next = pos_reg;
        if (cmd.refill_start || cmd.refill_end)
        begin
            pos_next = '0;
        end
        else if (cmd.pos_first)
        begin
            pos_next = CW'(1);
        end
        else if (cmd.pos_inc)
        begin
            pos_next = pos_reg + CW'(1);
        end

        spill_idx_next = spill_idx_reg;
        if (cmd.spill_clr)
        begin
            spill_idx_next = '0;
        end
        else if (cmd.spill_inc)
        begin
            spill_idx_next = spill_idx_reg + CW'(1);
        end

        refill_next = refill_reg;
        if (cmd.refill_start)
        begin
            refill_next = 1'b1;
        end
        else if (cmd.refill_end)
        begin
            refill_next = 1'b0;
        end

        modified_next = modified_reg | cmd.set_modified;

        case (cmd.blk_sel)
            cfs_pkg::BS_ITEM:    blk_sel_val = blk_reg;
            cfs_pkg::BS_RD:      blk_sel_val = rd_data_reg;
            cfs_pkg::BS_PENDING: blk_sel_val = pending_reg;
            default:             blk_sel_val = '0;
        endcase
        case (cmd.word_sel)
            cfs_pkg::WS_COUNT: word_sel_val = BW'(count_reg);
            cfs_pkg::WS_RD:    word_sel_val = rd_data_reg;
            cfs_pkg::WS_WORD:  word_sel_val = word_reg;
            default:           word_sel_val = '0;
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pos_reg       <= '0;
            spill_idx_reg <= '0;
            refill_reg    <= 1'b0;
            modified_reg  <= 1'b0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            spill_idx_reg <= spill_idx_next;
            refill_reg    <= refill_next;
            modified_reg  <= modified_next;
            if (cmd.refill_start)
            begin
                pending_reg <= rd_data_reg;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg <= kind;
            blk_reg  <= block_number;
            word_reg <= group_word;
        end
        if (cmd.out_load)
        begin
            status_reg       <= cmd.out_status;
            blk_res_reg      <= blk_sel_val;
            word_res_reg     <= word_sel_val;
            last_reg         <= cmd.out_last;
            modified_res_reg <= modified_next;
        end
    end

    always_comb
    begin
        stat.kind       = kind_reg;
        stat.refill     = refill_reg;
        stat.count_zero = (count_reg == '0);
        stat.count_full = (count_reg >= CW'(STACK_DEPTH));
        stat.pos_zero   = (pos_reg == '0);
        stat.pos_last   = (pos_reg >= CW'(STACK_DEPTH));
        stat.word_big   = (word_reg > BW'(STACK_DEPTH));
        stat.rd_zero    = (rd_data_reg == '0);
        stat.spill_done = (spill_idx_reg == CW'(STACK_DEPTH));
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign block_number_res = blk_res_reg;
    assign spill_word       = word_res_reg;
    assign last             = last_reg;
    assign modified         = modified_res_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !refill_reg |-> pos_reg == '0)
        else $error("refill position moved without a refill");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before taken");

    a_modified_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(modified_reg) |-> modified_reg)
        else $error("modified flag cleared");
`endif

endmodule

### sv/chained_free_block_stack_top.sv
// top level of the chained free block stack
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    kind, block_number, group_word
//  out      output     out_valid/out_ready  status, block_number_res, spill_word, last, modified
//
// one transaction at a time: a group word, a rejected request or an empty-stack allocation ends
// after decode; a free goes through decode and push, any other allocation through decode and a
// stack memory read. a free into a full stack first walks out STACK_DEPTH+1 spill words (the
// count word, then every entry) before the push; steps with a result wait while the output stalls.
// each result waits in one output register; the next transaction is taken while it waits.
// reset clears the count, flags and refill position; the stack memory is not cleared.
module chained_free_block_stack_top
#(
    parameter int STACK_DEPTH = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cfs_pkg::KIND_W-1:0]     kind,
    input  logic [cfs_pkg::BLK_W-1:0]      block_number,
    input  logic [cfs_pkg::BLK_W-1:0]      group_word,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cfs_pkg::STATUS_W-1:0]   status,
    output logic [cfs_pkg::BLK_W-1:0]      block_number_res,
    output logic [cfs_pkg::BLK_W-1:0]      spill_word,
    output logic                           last,
    output logic                           modified
);

    cfs_pkg::cfs_cmd_t  cmd;
    cfs_pkg::cfs_stat_t stat;

    cfs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cfs_dp
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .kind             (kind),
        .block_number     (block_number),
        .group_word       (group_word),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .block_number_res (block_number_res),
        .spill_word       (spill_word),
        .last             (last),
        .modified         (modified)
    );

endmodule

### dv/tb_top.sv
// testbench for the chained free block stack: directed table, then random traffic
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;
    localparam int RAND_ITEMS = 60;
    localparam logic [cfs_pkg::KIND_W-1:0] KIND_NONE = 2'd3;
    localparam logic [cfs_pkg::BLK_W-1:0] BLK_MAX = 31'h7FFFFFFF;
    localparam logic [cfs_pkg::BLK_W-1:0] BLK_ALT = 31'h2AAAAAAA;

    typedef struct packed {
        logic [cfs_pkg::STATUS_W-1:0] status;
        logic [cfs_pkg::BLK_W-1:0]    blk;
        logic [cfs_pkg::BLK_W-1:0]    word;
        logic                         last;
        logic                         modified;
    } res_t;

    // one row of the directed table; rows with rnd set draw their payload at random
    typedef struct packed {
        logic [cfs_pkg::KIND_W-1:0]   kind;
        logic [cfs_pkg::BLK_W-1:0]    blk;
        logic [cfs_pkg::BLK_W-1:0]    word;
        logic [5:0]                   reps;
        logic                         rnd;
        logic                         typed;
        logic [cfs_pkg::STATUS_W-1:0] e_status;
        logic [cfs_pkg::BLK_W-1:0]    e_blk;
        logic [cfs_pkg::BLK_W-1:0]    e_word;
        logic                         e_mod;
    } step_t;

    logic                         clk;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [cfs_pkg::KIND_W-1:0]   kind = cfs_pkg::KIND_ALLOC;
    logic [cfs_pkg::BLK_W-1:0]    block_number = '0;
    logic [cfs_pkg::BLK_W-1:0]    group_word = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [cfs_pkg::STATUS_W-1:0] status;
    logic [cfs_pkg::BLK_W-1:0]    block_number_res;
    logic [cfs_pkg::BLK_W-1:0]    spill_word;
    logic                         last;
    logic                         modified;

    chained_free_block_stack_top #(.STACK_DEPTH(DEPTH)) uut (.*);

    // predicted block state
    logic [cfs_pkg::BLK_W-1:0] stack_img [DEPTH];
    int unsigned               stack_cnt = 0;
    logic                      mod_flag = 1'b0;
    logic                      refilling = 1'b0;
    int unsigned               refill_pos = 0;
    logic [cfs_pkg::BLK_W-1:0] pending_blk = '0;

    res_t want_q[$];
    int   mismatches = 0;
    bit   calm = 1'b0;
    bit   lean_up = 1'b1;
    int   out_hold = 0;
    int   out_stall;

    step_t plan [21] = '{
        '{KIND_NONE, 31'd0, 31'd0, 6'd1, 1'b0, 1'b1,
          cfs_pkg::ST_UNEXPECTED, 31'd0, 31'd0, 1'b0},
        '{cfs_pkg::KIND_GROUP, 31'd0, BLK_MAX, 6'd1, 1'b0, 1'b1,
          cfs_pkg::ST_UNEXPECTED, 31'd0, 31'd0, 1'b0},
        '{cfs_pkg::KIND_ALLOC, 31'd0, 31'd0, 6'd1, 1'b0, 1'b1,
          cfs_pkg::ST_NO_SPACE, 31'd0, 31'd0, 1'b1},
        '{cfs_pkg::KIND_FREE, BLK_MAX, 31'd0, 6'd1, 1'b0, 1'b1,
          cfs_pkg::ST_FREED, BLK_MAX, 31'd0, 1'b1},
        '{cfs_pkg::KIND_ALLOC, 31'd0, 31'd0, 6'd1, 1'b0, 1'b1,
          cfs_pkg::ST_ALLOCATED, BLK_MAX, 31'd0, 1'b1},
        '{cfs_pkg::KIND_ALLOC, 31'd0, 31'd0, 6'd1, 1'b0, 1'b1,
          cfs_pkg::ST_NO_SPACE, 31'd0, 31'd0, 1'b1},
        '{cfs_pkg::KIND_FREE, 31'd1, 31'd0, 6'd1, 1'b0, 1'b1,
          cfs_pkg::ST_FREED, 31'd1, 31'd0, 1'b1},
        '{cfs_pkg::KIND_FREE, 31'd0, 31'd0, 6'd30, 1'b1, 1'b0,
          cfs_pkg::ST_FREED, 31'd0, 31'd0, 1'b1},
        '{cfs_pkg::KIND_FREE, BLK_ALT, 31'd0, 6'd1, 1'b0, 1'b0,
          cfs_pkg::ST_FREED, 31'd0, 31'd0, 1'b1},
        '{cfs_pkg::KIND_ALLOC, 31'd0, 31'd0, 6'd1, 1'b0, 1'b1,
          cfs_pkg::ST_READ_GROUP, BLK_ALT, 31'd0, 1'b1},
        '{cfs_pkg::KIND_FREE, 31'd3, 31'd0, 6'd1, 1'b0, 1'b1,
          cfs_pkg::ST_UNEXPECTED, 31'd0, 31'd0, 1'b1},
        '{cfs_pkg::KIND_ALLOC, 31'd0, 31'd0, 6'd1, 1'b0, 1'b1,
          cfs_pkg::ST_UNEXPECTED, 31'd0, 31'd0, 1'b1},
        '{cfs_pkg::KIND_GROUP, 31'd0, 31'(DEPTH + 1), 6'd1, 1'b0, 1'b1,
          cfs_pkg::ST_BAD_GROUP, BLK_ALT, 31'(DEPTH + 1), 1'b1},
        '{cfs_pkg::KIND_GROUP, 31'd0, 31'd0, 6'(DEPTH), 1'b1, 1'b0,
          cfs_pkg::ST_ALLOCATED, 31'd0, 31'd0, 1'b1},
        '{cfs_pkg::KIND_FREE, 31'd5, 31'd0, 6'd1, 1'b0, 1'b0,
          cfs_pkg::ST_FREED, 31'd0, 31'd0, 1'b1},
        '{cfs_pkg::KIND_ALLOC, 31'd0, 31'd0, 6'd1, 1'b0, 1'b1,
          cfs_pkg::ST_READ_GROUP, 31'd5, 31'd0, 1'b1},
        '{cfs_pkg::KIND_GROUP, 31'd0, 31'd0, 6'd1, 1'b0, 1'b0,
          cfs_pkg::ST_ALLOCATED, 31'd0, 31'd0, 1'b1},
        '{cfs_pkg::KIND_GROUP, 31'd0, 31'd0, 6'(DEPTH), 1'b1, 1'b0,
          cfs_pkg::ST_ALLOCATED, 31'd0, 31'd0, 1'b1},
        '{cfs_pkg::KIND_ALLOC, 31'd0, 31'd0, 6'd1, 1'b0, 1'b1,
          cfs_pkg::ST_NO_SPACE, 31'd0, 31'd0, 1'b1},
        '{cfs_pkg::KIND_FREE, 31'd0, 31'd0, 6'd1, 1'b0, 1'b1,
          cfs_pkg::ST_FREED, 31'd0, 31'd0, 1'b1},
        '{cfs_pkg::KIND_ALLOC, 31'd0, 31'd0, 6'd1, 1'b0, 1'b1,
          cfs_pkg::ST_NO_SPACE, 31'd0, 31'd0, 1'b1}
    };

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void book_result(input logic [cfs_pkg::STATUS_W-1:0] st,
                                        input logic [cfs_pkg::BLK_W-1:0] b,
                                        input logic [cfs_pkg::BLK_W-1:0] w, input logic lst);
        res_t r;
        r.status = st;
        r.blk = b;
        r.word = w;
        r.last = lst;
        r.modified = mod_flag;
        want_q.push_back(r);
    endfunction

    // apply one accepted transaction to the predicted state and queue what it yields
    function automatic void advance_stack(input logic [cfs_pkg::KIND_W-1:0] k,
                                          input logic [cfs_pkg::BLK_W-1:0] b,
                                          input logic [cfs_pkg::BLK_W-1:0] w);
        logic [cfs_pkg::BLK_W-1:0] top;
        if (k == cfs_pkg::KIND_ALLOC && !refilling)
        begin
            mod_flag = 1'b1;
            if (stack_cnt == 0)
                book_result(cfs_pkg::ST_NO_SPACE, '0, '0, 1'b1);
            else
            begin
                stack_cnt--;
                top = stack_img[stack_cnt];
                if (top == '0)
                begin
                    // end marker: the volume is full
                    stack_cnt = 1;
                    book_result(cfs_pkg::ST_NO_SPACE, '0, '0, 1'b1);
                end
                else if (stack_cnt == 0)
                begin
                    refilling = 1'b1;
                    refill_pos = 0;
                    pending_blk = top;
                    book_result(cfs_pkg::ST_READ_GROUP, top, '0, 1'b1);
                end
                else
                    book_result(cfs_pkg::ST_ALLOCATED, top, '0, 1'b1);
            end
        end
        else if (k == cfs_pkg::KIND_FREE && !refilling)
        begin
            mod_flag = 1'b1;
            if (stack_cnt == 0)
            begin
                stack_cnt = 1;
                stack_img[0] = '0;
            end
            if (stack_cnt >= DEPTH)
            begin
                book_result(cfs_pkg::ST_SPILL_WORD, b, 31'(stack_cnt), 1'b0);
                for (int i = 0; i < DEPTH; i++)
                    book_result(cfs_pkg::ST_SPILL_WORD, b, stack_img[i], 1'b0);
                stack_cnt = 0;
            end
            stack_img[stack_cnt] = b;
            stack_cnt++;
            book_result(cfs_pkg::ST_FREED, b, '0, 1'b1);
        end
        else if (k == cfs_pkg::KIND_GROUP && refilling)
        begin
            if (refill_pos == 0)
            begin
                refill_pos = 1;
                if (w > DEPTH)
                begin
                    stack_cnt = DEPTH;
                    book_result(cfs_pkg::ST_BAD_GROUP, pending_blk, w, 1'b1);
                end
                else
                    stack_cnt = 32'(w);
            end
            else
            begin
                stack_img[refill_pos - 1] = w;
                if (refill_pos >= DEPTH)
                begin
                    refilling = 1'b0;
                    refill_pos = 0;
                    mod_flag = 1'b1;
                    book_result(cfs_pkg::ST_ALLOCATED, pending_blk, '0, 1'b1);
                end
                else
                    refill_pos++;
            end
        end
        else
            book_result(cfs_pkg::ST_UNEXPECTED, '0, '0, 1'b1);
    endfunction

    // well-formed traffic for the current state, with some noise mixed in
    function automatic void pick_random(output logic [cfs_pkg::KIND_W-1:0] k,
                                        output logic [cfs_pkg::BLK_W-1:0] b,
                                        output logic [cfs_pkg::BLK_W-1:0] w);
        int roll;
        roll = $urandom_range(0, 99);
        b = 31'($urandom);
        w = 31'($urandom);
        if (refilling)
        begin
            if (roll < 4)
                k = roll[0] ? cfs_pkg::KIND_FREE : (roll[1] ? cfs_pkg::KIND_ALLOC : KIND_NONE);
            else
            begin
                k = cfs_pkg::KIND_GROUP;
                if (refill_pos == 0)
                begin
                    if (roll < 84)
                        w = 31'($urandom_range(0, DEPTH));
                    else if (roll < 92)
                        w = 31'($urandom_range(DEPTH + 1, 63));
                end
                else if (refill_pos == 1 && roll < 50)
                    w = '0;
                else if (roll < 7)
                    w = '0;
            end
        end
        else
        begin
            if (roll < 5)
                k = roll[0] ? cfs_pkg::KIND_GROUP : KIND_NONE;
            else
                k = ($urandom_range(0, 99) < (lean_up ? 85 : 20)) ? cfs_pkg::KIND_FREE
                                                                 : cfs_pkg::KIND_ALLOC;
            if ($urandom_range(0, 19) == 0)
                b = '0;
        end
    endfunction

    task automatic send_item(input logic [cfs_pkg::KIND_W-1:0] k,
                             input logic [cfs_pkg::BLK_W-1:0] b,
                             input logic [cfs_pkg::BLK_W-1:0] w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        block_number <= b;
        group_word <= w;
        do @(posedge clk); while (!in_ready);
        advance_stack(k, b, w);
    endtask

    // hold the input side until every queued result has come back
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (want_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [cfs_pkg::KIND_W-1:0] k;
        logic [cfs_pkg::BLK_W-1:0]  b;
        logic [cfs_pkg::BLK_W-1:0]  w;
        res_t                       fixed;
        bit                         was_full;
        bit                         was_refill;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
        begin
            for (int j = 0; j < plan[r].reps; j++)
            begin
                b = plan[r].rnd ? 31'($urandom) : plan[r].blk;
                w = plan[r].rnd ? 31'($urandom) : plan[r].word;
                send_item(plan[r].kind, b, w);
                if (plan[r].typed)
                begin
                    void'(want_q.pop_back());
                    fixed = '{plan[r].e_status, plan[r].e_blk, plan[r].e_word, 1'b1,
                              plan[r].e_mod};
                    want_q.push_back(fixed);
                end
            end
        end
        settle();

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 30 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (n == RAND_ITEMS / 2)
                settle();
            pick_random(k, b, w);
            was_full = !refilling && stack_cnt >= DEPTH;
            was_refill = refilling;
            send_item(k, b, w);
            // fill toward a spill, then drain toward a refill
            if (was_refill && !refilling)
                lean_up = 1'($urandom_range(0, 1));
            else if (refilling || stack_cnt <= 1)
                lean_up = 1'b1;
            if (was_full && k == cfs_pkg::KIND_FREE)
                lean_up = 1'b0;
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (want_q.size() != 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && want_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // output side may drop ready for a random stall after each result it takes, unless calm is set
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_hold <= 0;
        end
        else if (out_hold != 0)
            out_hold <= out_hold - 1;
        else if (out_ready && out_valid)
        begin
            out_stall = calm ? 0 : $urandom_range(0, 6);
            if (out_stall != 0)
            begin
                out_ready <= 1'b0;
                out_hold <= out_stall - 1;
            end
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (want_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb_top: result with nothing pending: status %0d blk %h word %h",
                             status, block_number_res, spill_word);
            end
            else
            begin
                want = want_q.pop_front();
                if (status !== want.status || block_number_res !== want.blk
                    || spill_word !== want.word || last !== want.last
                    || modified !== want.modified)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"tb_top: mismatch (want/got) status %0d/%0d blk %h/%h ",
                                  "word %h/%h last %b/%b mod %b/%b"},
                                 want.status, status, want.blk, block_number_res,
                                 want.word, spill_word, want.last, last,
                                 want.modified, modified);
                end
            end
        end
    end

    // a correct run takes well under a millisecond even with every stall at its longest
    initial
    begin
        #4_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
